// File: src/line_line_intersect_3d_top_assert.svh
// Assertion macros for the line intersection block.
// Used by the top level only; define NO_ASSERTIONS to drop all checks.
`ifndef LINE_LINE_INTERSECT_3D_TOP_ASSERT_SVH
`define LINE_LINE_INTERSECT_3D_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// cond must never hold outside reset
`define LLX_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("llx assertion failed");
// whenever ante holds, cons must hold in the same cycle
`define LLX_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llx assertion failed");
`else
`define LLX_ASSERT_NEVER(lbl, clk, rst, cond)
`define LLX_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/llx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 3D line intersection block.
// No dependencies.
package llx_pkg;

  localparam int LIMIT_WIDTH = 23;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 23'd1;

  localparam int KIND_WIDTH = 2;
  localparam logic [KIND_WIDTH-1:0] KIND_NONE       = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_POINT      = 2'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_COINCIDENT = 2'd2;

  // operand slice of the chunked multipliers
  localparam int MUL_CHUNK = 24;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: src/llx_delay.sv
`timescale 1ns / 1ps
// Enabled shift line that holds payload in step with the back pipeline.
// No dependencies.
module llx_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// File: src/llx_mul.sv
`timescale 1ns / 1ps
// Signed multiplier cut into chunk products, three register stages.
// Depends on llx_pkg (chunk size).
module llx_mul #(
  parameter int AW = 24,
  parameter int BW = 24
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [AW-1:0]   a,
  input  logic signed [BW-1:0]   b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CW = llx_pkg::MUL_CHUNK;
  localparam int NA = (AW + CW - 1) / CW;
  localparam int NB = (BW + CW - 1) / CW;
  localparam int PW = AW + BW;

  logic signed [NA*CW-1:0] a_ext;
  logic signed [NB*CW-1:0] b_ext;
  logic signed [CW:0]      ac [NA];
  logic signed [CW:0]      bc [NB];
  logic signed [2*CW+1:0]  pp [NA][NB];
  logic signed [PW-1:0]    row_next [NA];
  logic signed [PW-1:0]    row [NA];
  logic signed [PW-1:0]    p_next;

  assign a_ext = (NA*CW)'(a);
  assign b_ext = (NB*CW)'(b);

  // low chunks are unsigned, the top chunk carries the sign
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      ac[i] = $signed({(i == NA - 1) ? a_ext[(i+1)*CW-1] : 1'b0, a_ext[i*CW +: CW]});
    end
    for (int j = 0; j < NB; j++) begin
      bc[j] = $signed({(j == NB - 1) ? b_ext[(j+1)*CW-1] : 1'b0, b_ext[j*CW +: CW]});
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (PW'(pp[i][j]) <<< (j * CW));
      end
    end
    p_next = '0;
    for (int i = 0; i < NA; i++) begin
      p_next = p_next + (row[i] <<< (i * CW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ac[i] * bc[j];
        end
        row[i] <= row_next[i];
      end
      p <= p_next;
    end
  end

endmodule

// File: src/llx_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest.
// Flags quotients of 2^(W+1) or more as overflow. No package use.
module llx_div #(
  parameter int W  = 24,
  parameter int NW = 125,
  parameter int DW = 98
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [W+1:0]  quo,
  output logic          ovf
);

  localparam int RW = NW + 1;
  localparam int NS = W + 2;

  logic [RW-1:0] r   [NS];
  logic [W:0]    q   [NS];
  logic [DW-1:0] dd  [NS];
  logic          ov  [NS];
  logic [RW-1:0] trial [NS];
  logic          rnd;

  always_comb begin
    trial[0] = RW'(den) << (W + 1);
    for (int j = 1; j < NS; j++) begin
      trial[j] = RW'(dd[j-1]) << (W + 1 - j);
    end
    rnd = (r[NS-1] << 1) >= RW'(dd[NS-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= RW'(num);
      q[0]  <= '0;
      dd[0] <= den;
      ov[0] <= RW'(num) >= trial[0];
      for (int j = 1; j < NS; j++) begin
        dd[j] <= dd[j-1];
        ov[j] <= ov[j-1];
        if (r[j-1] >= trial[j]) begin
          r[j] <= r[j-1] - trial[j];
          q[j] <= q[j-1] | ((W+1)'(1) << (W + 1 - j));
        end else begin
          r[j] <= r[j-1];
          q[j] <= q[j-1];
        end
      end
      quo <= (W+2)'(q[NS-1]) + (W+2)'(rnd);
      ovf <= ov[NS-1];
    end
  end

endmodule

// File: src/llx_fifo.sv
`timescale 1ns / 1ps
// Short request queue between the front and the back of the block.
// Depends on llx_pkg (depth, status struct).
module llx_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  pop,
  output logic [WIDTH-1:0]      rdata,
  output llx_pkg::q_stat_t      stat
);

  localparam int DEPTH = llx_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  assign rdata      = mem[rd_ptr];
  assign stat.full  = count == CNTW'(DEPTH);
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/llx_front.sv
`timescale 1ns / 1ps
// Front end: takes a line pair, forms p2-p1 and d1 x d2 and queues the request.
// Depends on llx_pkg (queue status).
module llx_front #(
  parameter int W = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [12*W-1:0]       in_item,
  input  llx_pkg::q_stat_t      q_stat,
  output logic                  push,
  output logic [18*W+5:0]       entry
);

  logic              f_valid;
  logic [12*W-1:0]   f_item;
  logic signed [W-1:0]   p1 [3];
  logic signed [W-1:0]   d1 [3];
  logic signed [W-1:0]   p2 [3];
  logic signed [W-1:0]   d2 [3];
  logic signed [W:0]     diff [3];
  logic signed [2*W:0]   n [3];
  logic signed [2*W:0]   e1 [3];
  logic signed [2*W:0]   e2 [3];

  assign push     = f_valid && !q_stat.full;
  assign in_ready = !f_valid || !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item <= in_item;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p1[k] = $signed(f_item[k*W +: W]);
      d1[k] = $signed(f_item[(3+k)*W +: W]);
      p2[k] = $signed(f_item[(6+k)*W +: W]);
      d2[k] = $signed(f_item[(9+k)*W +: W]);
      diff[k] = (W+1)'(p2[k]) - (W+1)'(p1[k]);
      e1[k] = (2*W+1)'(d1[k]);
      e2[k] = (2*W+1)'(d2[k]);
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
  end

  // p2 travels only as p2-p1; pack d2 where the back expects it
  assign entry = {n[2], n[1], n[0], diff[2], diff[1], diff[0],
                  f_item[12*W-1:9*W], f_item[6*W-1:0]};

endmodule

// File: src/llx_back.sv
`timescale 1ns / 1ps
// Back end: products, tests, three division lanes and the result register.
// Depends on llx_pkg, llx_mul, llx_delay, llx_div and the queue status struct.
module llx_back #(
  parameter int W = 24,
  parameter int F = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [18*W+5:0]                entry,
  input  llx_pkg::q_stat_t               q_stat,
  output logic                           pop,
  input  logic [llx_pkg::LIMIT_WIDTH-1:0] limit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [llx_pkg::KIND_WIDTH-1:0] kind,
  output logic [3*W-1:0]                 coord,
  output logic                           clipped
);

  localparam int LW   = llx_pkg::LIMIT_WIDTH;
  localparam int KW   = llx_pkg::KIND_WIDTH;
  localparam int LAST = W + 14;
  localparam int DW   = 4 * W + 2;
  localparam int PW   = 5 * W + 5;
  localparam int C1   = 4 * W + 4;
  localparam int C2   = 2 * LW + 2 * F;
  localparam int C3   = LW + 3 * F;
  localparam int C12  = (C1 > C2) ? C1 : C2;
  localparam int CMPW = (C12 > C3) ? C12 : C3;
  localparam logic signed [W+3:0] HI_X = {{5{1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [W+3:0] LO_X = {{5{1'b1}}, {(W-1){1'b0}}};

  logic            en;
  logic [LAST:1]   vld;
  logic [18*W+5:0] e1;

  logic signed [W-1:0]   d1 [3];
  logic signed [W-1:0]   d2 [3];
  logic signed [W:0]     diff [3];
  logic signed [2*W:0]   n1 [3];
  logic signed [2*W+1:0] xd [3];
  logic signed [2*W+1:0] x1 [3];
  logic signed [2*W+1:0] x2 [3];
  logic signed [2*W+1:0] c1 [3];
  logic signed [2*W+1:0] c2 [3];
  logic signed [2*W:0]   n2 [3];

  logic signed [4*W+1:0] nn [3];
  logic signed [3*W+1:0] dn [3];
  logic signed [4*W+3:0] ccp [3];
  logic signed [4*W+2:0] nc [3];

  logic [DW-1:0]         dsum5;
  logic signed [3*W+3:0] ssum5;
  logic [DW-1:0]         dsum6;
  logic signed [3*W+3:0] ssum6;
  logic [4*W+3:0]        cc6;
  logic signed [4*W+4:0] nsum6;
  logic [2*LW-1:0]       lim_sq;
  logic [CMPW-1:0]       thr_par, thr_coin, thr_copl;
  logic [3*W+3:0]        sabs;
  logic [KW-1:0]         kind_next, kind7, kind_f;
  logic [3*W-1:0]        d1_6;
  logic signed [PW-1:0]  prod [3];
  logic [PW-1:0]         mag10 [3];
  logic [2:0]            neg10;
  logic [2:0]            neg_f;
  logic [DW-1:0]         den10;
  logic [W+1:0]          quo [3];
  logic [2:0]            ovf;
  logic [3*W-1:0]        p1_f;
  logic [3*W-1:0]        coord_next;
  logic                  clip_next;

  // the whole pipeline moves unless a finished result is waiting
  assign en        = !vld[LAST] || out_ready;
  assign pop       = en && !q_stat.empty;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:1], pop};
    end
  end

  // stage 1: hold the request
  always_ff @(posedge clk) begin
    if (en) begin
      e1 <= entry;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1[k]   = $signed(e1[(3+k)*W +: W]);
      d2[k]   = $signed(e1[(6+k)*W +: W]);
      diff[k] = $signed(e1[9*W + k*(W+1) +: W+1]);
      n1[k]   = $signed(e1[12*W + 3 + k*(2*W+1) +: 2*W+1]);
      xd[k]   = (2*W+2)'(diff[k]);
      x1[k]   = (2*W+2)'(d1[k]);
      x2[k]   = (2*W+2)'(d2[k]);
    end
  end

  // stage 2: (p2-p1) x d1 and (p2-p1) x d2
  always_ff @(posedge clk) begin
    if (en) begin
      c1[0] <= xd[1] * x1[2] - xd[2] * x1[1];
      c1[1] <= xd[2] * x1[0] - xd[0] * x1[2];
      c1[2] <= xd[0] * x1[1] - xd[1] * x1[0];
      c2[0] <= xd[1] * x2[2] - xd[2] * x2[1];
      c2[1] <= xd[2] * x2[0] - xd[0] * x2[2];
      c2[2] <= xd[0] * x2[1] - xd[1] * x2[0];
      for (int k = 0; k < 3; k++) begin
        n2[k] <= n1[k];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_prod
    llx_mul #(.AW(2*W+1), .BW(2*W+1)) u_nn (
      .clk(clk), .en(en), .a(n1[k]), .b(n1[k]), .p(nn[k]));
    llx_mul #(.AW(W+1), .BW(2*W+1)) u_dn (
      .clk(clk), .en(en), .a(diff[k]), .b(n1[k]), .p(dn[k]));
    llx_mul #(.AW(2*W+2), .BW(2*W+2)) u_cc (
      .clk(clk), .en(en), .a(c1[k]), .b(c1[k]), .p(ccp[k]));
    llx_mul #(.AW(2*W+2), .BW(2*W+1)) u_nc (
      .clk(clk), .en(en), .a(c2[k]), .b(n2[k]), .p(nc[k]));
    llx_mul #(.AW(W), .BW(4*W+5)) u_dq (
      .clk(clk), .en(en), .a($signed(d1_6[k*W +: W])), .b(nsum6), .p(prod[k]));
  end

  // stages 5 and 6: sums of products
  always_ff @(posedge clk) begin
    if (en) begin
      dsum5 <= DW'(nn[0] + nn[1] + nn[2]);
      ssum5 <= (3*W+4)'(dn[0]) + (3*W+4)'(dn[1]) + (3*W+4)'(dn[2]);
      dsum6 <= dsum5;
      ssum6 <= ssum5;
      cc6   <= (4*W+4)'(ccp[0] + ccp[1] + ccp[2]);
      nsum6 <= (4*W+5)'(nc[0]) + (4*W+5)'(nc[1]) + (4*W+5)'(nc[2]);
    end
  end

  always_ff @(posedge clk) begin
    lim_sq <= (2*LW)'(limit) * (2*LW)'(limit);
  end

  // stage 7: parallel, coincident and coplanar tests
  always_comb begin
    thr_par  = CMPW'(limit) << (3 * F);
    thr_coin = CMPW'(lim_sq) << (2 * F);
    thr_copl = CMPW'(limit) << (2 * F);
    sabs     = ssum6[3*W+3] ? (3*W+4)'(-ssum6) : (3*W+4)'(ssum6);
    if (CMPW'(dsum6) <= thr_par) begin
      kind_next = (CMPW'(cc6) <= thr_coin) ? llx_pkg::KIND_COINCIDENT : llx_pkg::KIND_NONE;
    end else begin
      kind_next = (CMPW'(sabs) <= thr_copl) ? llx_pkg::KIND_POINT : llx_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind7 <= kind_next;
    end
  end

  llx_delay #(.WIDTH(3*W), .DEPTH(5)) u_d1_dly (
    .clk(clk), .en(en), .d(e1[3*W +: 3*W]), .q(d1_6));

  llx_delay #(.WIDTH(DW), .DEPTH(4)) u_den_dly (
    .clk(clk), .en(en), .d(dsum6), .q(den10));

  // stage 10: split sign and magnitude of d1*N
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg10[k] <= prod[k][PW-1];
        mag10[k] <= prod[k][PW-1] ? PW'(-prod[k]) : PW'(prod[k]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    llx_div #(.W(W), .NW(PW), .DW(DW)) u_div (
      .clk(clk), .en(en), .num(mag10[k]), .den(den10), .quo(quo[k]), .ovf(ovf[k]));
  end

  llx_delay #(.WIDTH(3), .DEPTH(W+3)) u_neg_dly (
    .clk(clk), .en(en), .d(neg10), .q(neg_f));

  llx_delay #(.WIDTH(3*W), .DEPTH(W+12)) u_p1_dly (
    .clk(clk), .en(en), .d(e1[3*W-1:0]), .q(p1_f));

  llx_delay #(.WIDTH(KW), .DEPTH(W+6)) u_kind_dly (
    .clk(clk), .en(en), .d(kind7), .q(kind_f));

  // last stage: p1 + rounded offset, saturate
  always_comb begin
    logic signed [W+3:0] qs;
    logic signed [W+3:0] vsum;
    clip_next  = 1'b0;
    coord_next = '0;
    for (int k = 0; k < 3; k++) begin
      qs   = neg_f[k] ? -$signed((W+4)'(quo[k])) : $signed((W+4)'(quo[k]));
      vsum = (W+4)'($signed(p1_f[k*W +: W])) + qs;
      if (ovf[k]) begin
        coord_next[k*W +: W] = neg_f[k] ? LO_X[W-1:0] : HI_X[W-1:0];
        clip_next = 1'b1;
      end else if (vsum > HI_X) begin
        coord_next[k*W +: W] = HI_X[W-1:0];
        clip_next = 1'b1;
      end else if (vsum < LO_X) begin
        coord_next[k*W +: W] = LO_X[W-1:0];
        clip_next = 1'b1;
      end else begin
        coord_next[k*W +: W] = vsum[W-1:0];
      end
    end
    if (kind_f != llx_pkg::KIND_POINT) begin
      coord_next = '0;
      clip_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind    <= kind_f;
      coord   <= coord_next;
      clipped <= clip_next;
    end
  end

endmodule

// File: src/line_line_intersect_3d_top.sv
`timescale 1ns / 1ps
// Top level of the 3D line intersection block: config register, front, queue, back.
// Depends on llx_pkg, llx_front, llx_fifo, llx_back and the assertion header.
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------------
//  in        in_valid / in_ready     first/second point and direction, x y z
//  out       out_valid / out_ready   meet_kind, meet_x/y/z, clipped
//  cfg       cfg_valid / cfg_ready   cfg_data (near-zero limit)
//
// One line pair per cycle sustained while the output is not stalled. An accepted
// request passes the input register and the queue, then the back stages, most of
// them in the one-bit-per-stage dividers, before out_valid rises for it. Reset
// clears control and sets the limit to 1.
// A stalled output freezes the back pipeline; the 4-entry queue and the input
// register keep accepting until they fill. cfg_ready is always high.
module line_line_intersect_3d_top #(
  parameter int COORD_WIDTH   = 24,
  parameter int FRACTION_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_WIDTH-1:0]          first_point_x,
  input  logic signed [COORD_WIDTH-1:0]          first_point_y,
  input  logic signed [COORD_WIDTH-1:0]          first_point_z,
  input  logic signed [COORD_WIDTH-1:0]          first_dir_x,
  input  logic signed [COORD_WIDTH-1:0]          first_dir_y,
  input  logic signed [COORD_WIDTH-1:0]          first_dir_z,
  input  logic signed [COORD_WIDTH-1:0]          second_point_x,
  input  logic signed [COORD_WIDTH-1:0]          second_point_y,
  input  logic signed [COORD_WIDTH-1:0]          second_point_z,
  input  logic signed [COORD_WIDTH-1:0]          second_dir_x,
  input  logic signed [COORD_WIDTH-1:0]          second_dir_y,
  input  logic signed [COORD_WIDTH-1:0]          second_dir_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [llx_pkg::KIND_WIDTH-1:0]         meet_kind,
  output logic signed [COORD_WIDTH-1:0]          meet_x,
  output logic signed [COORD_WIDTH-1:0]          meet_y,
  output logic signed [COORD_WIDTH-1:0]          meet_z,
  output logic                                   clipped,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [llx_pkg::LIMIT_WIDTH-1:0]        cfg_data
);

`include "line_line_intersect_3d_top_assert.svh"

  localparam int W = COORD_WIDTH;

  logic [llx_pkg::LIMIT_WIDTH-1:0] near_zero_limit;
  logic [12*W-1:0]                 in_item;
  logic [18*W+5:0]                 q_wdata;
  logic [18*W+5:0]                 q_rdata;
  logic                            q_push;
  logic                            q_pop;
  llx_pkg::q_stat_t                q_stat;
  logic [3*W-1:0]                  coord;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_limit <= llx_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      near_zero_limit <= cfg_data;
    end
  end

  assign in_item = {second_dir_z, second_dir_y, second_dir_x,
                    second_point_z, second_point_y, second_point_x,
                    first_dir_z, first_dir_y, first_dir_x,
                    first_point_z, first_point_y, first_point_x};

  llx_front #(.W(W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .push     (q_push),
    .entry    (q_wdata)
  );

  llx_fifo #(.WIDTH(18*W+6)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  llx_back #(.W(W), .F(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .entry     (q_rdata),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .limit     (near_zero_limit),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (meet_kind),
    .coord     (coord),
    .clipped   (clipped)
  );

  assign meet_x = $signed(coord[W-1:0]);
  assign meet_y = $signed(coord[2*W-1:W]);
  assign meet_z = $signed(coord[3*W-1:2*W]);

  `LLX_ASSERT_NEVER(a_queue_full_and_empty, clk, rst, q_stat.full && q_stat.empty)
  `LLX_ASSERT_IMPL(a_stall_needs_full_queue, clk, rst, !in_ready, q_stat.full)
  `LLX_ASSERT_IMPL(a_no_point_zero_fields, clk, rst, out_valid && meet_kind != llx_pkg::KIND_POINT, meet_x == '0 && meet_y == '0 && meet_z == '0 && !clipped)

endmodule

// File: tb/sv/line_line_intersect_3d_top_tb.sv
`timescale 1ns / 1ps
// Testbench for line_line_intersect_3d_top: drives line pairs and tolerance writes,
// predicts each intersection in wide integers and checks every result in order.
// Depends on llx_pkg and the RTL of the block.
module line_line_intersect_3d_top_tb;

  localparam int CW = 24;
  localparam int FB = 12;
  localparam int SETTLE_CYCLES = CW + 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t pair_t [12];
  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic [llx_pkg::KIND_WIDTH-1:0] kind;
    coord_t x, y, z;
    logic clip;
  } meet_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t drv [12];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [llx_pkg::KIND_WIDTH-1:0] meet_kind;
  coord_t meet_x, meet_y, meet_z;
  logic clipped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [llx_pkg::LIMIT_WIDTH-1:0] cfg_data = '0;

  logic [llx_pkg::LIMIT_WIDTH-1:0] tol_limit = llx_pkg::LIMIT_RESET;
  meet_t pending_meets [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  initial for (int i = 0; i < 12; i++) drv[i] = '0;

  always #5 clk = ~clk;

  line_line_intersect_3d_top #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_point_x(drv[0]), .first_point_y(drv[1]), .first_point_z(drv[2]),
    .first_dir_x(drv[3]), .first_dir_y(drv[4]), .first_dir_z(drv[5]),
    .second_point_x(drv[6]), .second_point_y(drv[7]), .second_point_z(drv[8]),
    .second_dir_x(drv[9]), .second_dir_y(drv[10]), .second_dir_z(drv[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .meet_kind(meet_kind), .meet_x(meet_x), .meet_y(meet_y), .meet_z(meet_z),
    .clipped(clipped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic meet_t intersect_lines(pair_t pr,
                                            logic [llx_pkg::LIMIT_WIDTH-1:0] lim_raw);
    wide_t p1 [3], d1 [3], d2 [3], df [3], n [3], c [3];
    wide_t dd, cc, s, num, lim, mag, q, r, v;
    wide_t hi, lo;
    meet_t m;
    hi = (wide_t'(1) <<< (CW - 1)) - 1;
    lo = -(wide_t'(1) <<< (CW - 1));
    lim = wide_t'({1'b0, lim_raw});
    m.kind = llx_pkg::KIND_NONE; m.x = '0; m.y = '0; m.z = '0; m.clip = 1'b0;
    for (int k = 0; k < 3; k++) begin
      p1[k] = pr[k];
      d1[k] = pr[3 + k];
      d2[k] = pr[9 + k];
      df[k] = wide_t'(pr[6 + k]) - p1[k];
    end
    n[0] = d1[1] * d2[2] - d1[2] * d2[1];
    n[1] = d1[2] * d2[0] - d1[0] * d2[2];
    n[2] = d1[0] * d2[1] - d1[1] * d2[0];
    dd = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    if (dd <= (lim <<< (3 * FB))) begin
      // parallel: coincident when the offset has no part across d1
      c[0] = df[1] * d1[2] - df[2] * d1[1];
      c[1] = df[2] * d1[0] - df[0] * d1[2];
      c[2] = df[0] * d1[1] - df[1] * d1[0];
      cc = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
      if (cc <= ((lim * lim) <<< (2 * FB))) m.kind = llx_pkg::KIND_COINCIDENT;
    end else begin
      s = df[0] * n[0] + df[1] * n[1] + df[2] * n[2];
      if (s < 0) s = -s;
      if (s <= (lim <<< (2 * FB))) begin
        c[0] = df[1] * d2[2] - df[2] * d2[1];
        c[1] = df[2] * d2[0] - df[0] * d2[2];
        c[2] = df[0] * d2[1] - df[1] * d2[0];
        num = c[0] * n[0] + c[1] * n[1] + c[2] * n[2];
        m.kind = llx_pkg::KIND_POINT;
        for (int k = 0; k < 3; k++) begin
          v = d1[k] * num;
          mag = (v < 0) ? -v : v;
          q = mag / dd;
          r = mag - q * dd;
          // round half away from zero
          if ((r <<< 1) >= dd) q = q + 1;
          v = p1[k] + ((v < 0) ? -q : q);
          if (v > hi) begin v = hi; m.clip = 1'b1; end
          if (v < lo) begin v = lo; m.clip = 1'b1; end
          case (k)
            0: m.x = v[CW-1:0];
            1: m.y = v[CW-1:0];
            default: m.z = v[CW-1:0];
          endcase
        end
      end
    end
    return m;
  endfunction

  task automatic send_pair(pair_t pr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 12; i++) drv[i] <= pr[i];
    do @(posedge clk); while (!in_ready);
    pending_meets.push_back(intersect_lines(pr, tol_limit));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_meets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [llx_pkg::LIMIT_WIDTH-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_limit = value;
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom());
  endfunction

  function automatic coord_t rand_span(int half);
    return coord_t'($signed($urandom_range(2 * half - 1)) - half);
  endfunction

  // mostly well-formed geometry with random content, the rest raw noise
  function automatic pair_t rand_pair();
    pair_t pr;
    int pick, a, b, scale;
    coord_t pt [3];
    pick = $urandom_range(99);
    a = rand_span(1024);
    b = rand_span(1024);
    for (int k = 0; k < 3; k++) begin
      pt[k] = rand_span(1 << 21);
      pr[3 + k] = rand_span(1024);
      pr[9 + k] = rand_span(1024);
    end
    if (pick < 50) begin
      for (int k = 0; k < 3; k++) begin
        pr[k] = coord_t'(pt[k] - pr[3 + k] * a);
        pr[6 + k] = coord_t'(pt[k] - pr[9 + k] * b);
      end
      // nudge off the plane now and then to probe the tolerance
      if ($urandom_range(3) == 0) pr[8] = pr[8] + rand_span(8);
    end else if (pick < 75) begin
      scale = rand_span(4);
      for (int k = 0; k < 3; k++) begin
        pr[k] = pt[k];
        pr[9 + k] = coord_t'(pr[3 + k] * scale);
        pr[6 + k] = (pick < 62) ? coord_t'(pt[k] + pr[3 + k] * b) : rand_span(1 << 21);
      end
    end else begin
      for (int i = 0; i < 12; i++) pr[i] = rand_coord();
    end
    return pr;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_pair(rand_pair());
  endtask

  task automatic test_directed;
    coord_t mx, mn;
    pair_t pr;
    mx = coord_t'((1 << (CW - 1)) - 1);
    mn = coord_t'(-(1 << (CW - 1)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_pair('{0, 0, 0, 4096, 0, 0, 8192, -4096, 0, 0, 4096, 0});   // one point
    send_pair('{0, 0, 0, 4096, 0, 0, 0, 4096, 0, 8192, 0, 0});       // parallel apart
    send_pair('{0, 0, 0, 4096, 0, 0, 12288, 0, 0, -4096, 0, 0});     // same line
    send_pair('{0, 0, 0, 4096, 0, 0, 0, 0, 4096, 0, 4096, 0});       // skew
    send_pair('{100, -7, 3, 0, 0, 0, 5, 9, 1, 77, -3, 12});          // zero first dir
    send_pair('{100, -7, 3, 77, -3, 12, 5, 9, 1, 0, 0, 0});          // zero second dir
    send_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_pair('{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx});
    send_pair('{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn});
    send_pair('{mx, mn, mx, mn, mx, mn, mn, mx, mn, mx, mn, mx});
    send_pair('{mx, mn, 0, mn, mx, mn, 0, mx, mn, mx, mn, mx});
    // far meeting points that saturate high and low
    send_pair('{mx, 0, 0, 4096, 0, 0, 8000000, 4096, 0, 4096, -1, 0});
    send_pair('{mn, 0, 0, 4096, 0, 0, -8000000, 4096, 0, 4096, 1, 0});
    send_pair('{0, 0, 0, 3, 5, 0, 1, -5, 0, 0, 7, 0});               // fractional t
    send_pair('{1, 2, 3, mx, 1, 0, -4, 6, 0, 1, mx, 0});
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 12; j++) pr[j] = rand_coord();
      send_pair(pr);
    end
    drain();
  endtask

  task automatic test_limit_sweep;
    send_idle_pct = 17;
    recv_idle_pct = 72;
    write_limit('0);
    send_random(220);
    write_limit({llx_pkg::LIMIT_WIDTH{1'b1}});
    send_random(150);
    send_idle_pct = 72;
    recv_idle_pct = 17;
    write_limit(llx_pkg::LIMIT_WIDTH'($urandom_range(1, 4096)));
    send_random(220);
    write_limit(llx_pkg::LIMIT_WIDTH'($urandom()));
    send_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(llx_pkg::LIMIT_RESET);
    send_random(250);
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    send_random(80);
    drain();
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    meet_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_meets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind=%0d", meet_kind);
      end else begin
        want = pending_meets.pop_front();
        if (meet_kind !== want.kind || meet_x !== want.x || meet_y !== want.y ||
            meet_z !== want.z || clipped !== want.clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d (%0d,%0d,%0d) clip %0d, got %0d (%0d,%0d,%0d) clip %0d",
                     want.kind, want.x, want.y, want.z, want.clip,
                     meet_kind, meet_x, meet_y, meet_z, clipped);
        end
      end
    end
  end

  // watchdog: count cycles with work pending and no request moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        !(in_valid || cfg_valid || pending_meets.size() != 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limit_sweep();
    test_backpressure();
    if (mismatches == 0 && pending_meets.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
